>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker in fsg_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define FSG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is held.
`define FSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define FSG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/fsg_pkg.sv
// Package: types, codes and helpers of the falling sand grid block.
`default_nettype none
package fsg_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [8:0]  DIM_RESET = 9'd64;
    localparam logic [8:0]  DIM_MIN   = 9'd8;
    localparam logic [31:0] RNG_SEED  = 32'h9e3779b9;

    localparam logic [3:0] MAT_EMPTY = 4'd0;
    localparam logic [3:0] MAT_WALL  = 4'd1;
    localparam logic [3:0] MAT_SAND  = 4'd2;
    localparam logic [3:0] MAT_WATER = 4'd3;
    localparam logic [3:0] MAT_OIL   = 4'd4;
    localparam logic [3:0] MAT_EMBER = 4'd5;

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_POUR  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_AMB_EN  = 2'd2,
        CFG_AMB_MAT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [8:0] gw;
        logic [8:0] gh;
        logic       amb_en;
        logic [2:0] amb_mat;
        logic       resize;
    } t_cfg;

    typedef enum logic [4:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FS_RD,
        ST_FS_CUR,
        ST_FS_ASH,
        ST_FS_BELOW,
        ST_FS_DIAG_ISS,
        ST_FS_DIAG,
        ST_FS_SIDE_ISS,
        ST_FS_SIDE,
        ST_FS_WR2,
        ST_FS_NEXT,
        ST_AM_ISS,
        ST_AM_CHK,
        ST_PO_CELL,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    function automatic logic [31:0] xs32(input logic [31:0] s);
        logic [31:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // Cell byte for a freshly poured material: embers start at full heat.
    function automatic logic [7:0] mk_cell(input logic [2:0] mat);
        logic [3:0] m;
        m = {1'b0, mat};
        return {(m == MAT_EMBER) ? 4'hf : 4'h0, m};
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fsg_ifs.sv
// Channel interfaces: command in, result out, configuration write.
`default_nettype none
interface fsg_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [4:0] radius;
    logic [2:0] material;
    modport source (output valid, command, pos_x, pos_y, radius, material, input ready);
    modport sink   (input valid, command, pos_x, pos_y, radius, material, output ready);
endinterface

interface fsg_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] command_done;
    logic [7:0] cell_value;
    modport source (output valid, command_done, cell_value, input ready);
    modport sink   (input valid, command_done, cell_value, output ready);
endinterface

interface fsg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [8:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/fsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_q;
endmodule
`default_nettype wire

>>> hw/rtl/fsg_cfg.sv
// Configuration registers with size clamping and resize detection.
`default_nettype none
module fsg_cfg #(
    parameter int MAX_WIDTH  = fsg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fsg_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    fsg_cfg_if.sink    i_cfg,
    output fsg_pkg::t_cfg o_cfg
);
    import fsg_pkg::*;

    // The write port is 9 bits wide, so sizes never exceed 511.
    localparam int         WCAP  = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
    localparam int         HCAP  = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
    localparam logic [8:0] W_MAX = WCAP[8:0];
    localparam logic [8:0] H_MAX = HCAP[8:0];

    logic [8:0] r_gw, n_gw, r_gh, n_gh;
    logic       r_amb_en, n_amb_en;
    logic [2:0] r_amb_mat, n_amb_mat;
    logic       r_resize, n_resize;
    logic [8:0] w_clamp, h_clamp;
    logic       wr;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid;

    always_comb begin
        w_clamp = (i_cfg.wdata < DIM_MIN) ? DIM_MIN :
                  (i_cfg.wdata > W_MAX)   ? W_MAX : i_cfg.wdata;
        h_clamp = (i_cfg.wdata < DIM_MIN) ? DIM_MIN :
                  (i_cfg.wdata > H_MAX)   ? H_MAX : i_cfg.wdata;
        n_gw      = r_gw;
        n_gh      = r_gh;
        n_amb_en  = r_amb_en;
        n_amb_mat = r_amb_mat;
        n_resize  = 1'b0;
        if (wr) begin
            case (t_cfg_idx'(i_cfg.reg_index))
                CFG_WIDTH: begin
                    n_gw     = w_clamp;
                    n_resize = (w_clamp != r_gw);
                end
                CFG_HEIGHT: begin
                    n_gh     = h_clamp;
                    n_resize = (h_clamp != r_gh);
                end
                CFG_AMB_EN:  n_amb_en  = i_cfg.wdata[0];
                CFG_AMB_MAT: n_amb_mat = i_cfg.wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw      <= DIM_RESET;
            r_gh      <= DIM_RESET;
            r_amb_en  <= 1'b1;
            r_amb_mat <= 3'(MAT_SAND);
            r_resize  <= 1'b0;
        end else begin
            r_gw      <= n_gw;
            r_gh      <= n_gh;
            r_amb_en  <= n_amb_en;
            r_amb_mat <= n_amb_mat;
            r_resize  <= n_resize;
        end
    end

    assign o_cfg = '{gw: r_gw, gh: r_gh, amb_en: r_amb_en,
                     amb_mat: r_amb_mat, resize: r_resize};
endmodule
`default_nettype wire

>>> hw/rtl/fsg_seq.sv
// Command sequencer: frame scan, pour, clear and read over the cell RAM.
`default_nettype none
module fsg_seq #(
    parameter int MAX_WIDTH  = fsg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fsg_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    fsg_cmd_if.sink            i_cmd,
    fsg_res_if.source          o_res,
    input  wire fsg_pkg::t_cfg i_cfg,
    output logic [AW-1:0]      o_rd_addr,
    input  wire logic [7:0]    i_rd_data,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [7:0]         o_wr_data
);
    import fsg_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    t_state       r_state, n_state;
    logic [8:0]   r_x, n_x, r_y, n_y, r_nx, n_nx, r_aend, n_aend;
    logic         r_t, n_t, r_lf, n_lf;
    logic [7:0]   r_c, n_c, r_w2, n_w2;
    logic [31:0]  r_rng, n_rng;
    logic [AW-1:0] r_sweep, n_sweep;
    logic         r_clr_rep, n_clr_rep;
    logic [1:0]   r_cmd, n_cmd;
    logic [7:0]   r_px, n_px, r_py, n_py;
    logic [4:0]   r_rad, n_rad;
    logic [2:0]   r_mat, n_mat;
    logic signed [6:0] r_dx, n_dx, r_dy, n_dy;
    logic [7:0]   r_dval, n_dval;
    logic         r_ovalid, n_ovalid;
    logic [1:0]   r_ocmd, n_ocmd;
    logic [7:0]   r_oval, n_oval;

    logic [31:0]  rnd1;
    logic [3:0]   m;
    logic         go_left, nb_ok, liq;
    logic [8:0]   nb_x, cx, span, amb_x0;
    logic [4:0]   gw16;
    logic [10:0]  div_prod;
    logic [2:0]   amb_mat;
    logic signed [6:0] ir;
    logic signed [9:0] po_x, po_y;
    logic [5:0]   adx, ady;
    logic [12:0]  dist2;
    logic [9:0]   rad2;

    function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] y);
        return {YW'(y), XW'(x)};
    endfunction

    always_comb begin
        m       = r_c[3:0];
        liq     = (m == MAT_WATER) || (m == MAT_OIL);
        rnd1    = xs32(r_rng);
        // first neighbour tried lies against the scan direction
        go_left = (r_t == 1'b0) ? r_lf : !r_lf;
        nb_ok   = go_left ? (r_x != 9'd0) : ((r_x + 9'd1) != i_cfg.gw);
        nb_x    = go_left ? (r_x - 9'd1) : (r_x + 9'd1);
        // ambient span: 1 + gw/48, with /3 done as *43 >> 7
        gw16     = i_cfg.gw[8:4];
        div_prod = 11'(gw16) * 11'd43;
        span     = 9'd1 + 9'(div_prod[10:7]);
        cx       = {1'b0, i_cfg.gw[8:1]};
        amb_x0   = cx - span;
        amb_mat  = (i_cfg.amb_mat inside {[3'd2:3'd5]}) ? i_cfg.amb_mat : 3'(MAT_SAND);
        // pour geometry
        ir    = 7'(r_rad) + 7'sd1;
        po_x  = 10'(r_px) + 10'(r_dx);
        po_y  = 10'(r_py) + 10'(r_dy);
        adx   = (r_dx < 0) ? 6'(-r_dx) : 6'(r_dx);
        ady   = (r_dy < 0) ? 6'(-r_dy) : 6'(r_dy);
        dist2 = (13'(adx) * 13'(adx)) + (13'(ady) * 13'(ady));
        rad2  = 10'(r_rad) * 10'(r_rad);
    end

    always_comb begin
        n_state = r_state; n_x = r_x; n_y = r_y; n_nx = r_nx; n_aend = r_aend;
        n_t = r_t; n_lf = r_lf; n_c = r_c; n_w2 = r_w2; n_rng = r_rng;
        n_sweep = r_sweep; n_clr_rep = r_clr_rep; n_cmd = r_cmd;
        n_px = r_px; n_py = r_py; n_rad = r_rad; n_mat = r_mat;
        n_dx = r_dx; n_dy = r_dy; n_dval = r_dval;
        n_ovalid = r_ovalid; n_ocmd = r_ocmd; n_oval = r_oval;
        o_rd_addr = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = '0;
        // a pending size change takes the sequencer away from idle
        i_cmd.ready = (r_state == ST_IDLE) && !i_cfg.resize;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_SWEEP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_sweep;
                n_sweep   = r_sweep + 1'b1;
                if (&r_sweep) begin
                    n_dval  = 8'd0;
                    n_state = r_clr_rep ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd = i_cmd.command;
                    n_px  = i_cmd.pos_x;
                    n_py  = i_cmd.pos_y;
                    n_rad = i_cmd.radius;
                    n_mat = i_cmd.material;
                    n_dval = 8'd0;
                    case (t_cmd'(i_cmd.command))
                        CMD_STEP: begin
                            n_lf    = !r_lf;
                            n_y     = i_cfg.gh - 9'd2;
                            n_x     = !r_lf ? 9'd0 : (i_cfg.gw - 9'd1);
                            n_state = ST_FS_RD;
                        end
                        CMD_POUR: begin
                            n_dx    = -(7'(i_cmd.radius) + 7'sd1);
                            n_dy    = -(7'(i_cmd.radius) + 7'sd1);
                            n_state = (i_cmd.material inside {[3'd2:3'd5]}) ?
                                      ST_PO_CELL : ST_DONE;
                        end
                        CMD_CLEAR: begin
                            n_sweep   = '0;
                            n_clr_rep = 1'b1;
                            n_state   = ST_SWEEP;
                        end
                        CMD_READ: begin
                            if ((9'(i_cmd.pos_x) < i_cfg.gw) && (9'(i_cmd.pos_y) < i_cfg.gh)) begin
                                o_rd_addr = cell_addr(9'(i_cmd.pos_x), 9'(i_cmd.pos_y));
                                n_state   = ST_RD_WAIT;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_dval  = i_rd_data;
                n_state = ST_DONE;
            end
            ST_PO_CELL: begin
                if ((po_x >= 0) && (po_x < 10'(i_cfg.gw)) && (po_y >= 0) &&
                    (po_y < 10'(i_cfg.gh)) && (dist2 < 13'(rad2))) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cell_addr(po_x[8:0], po_y[8:0]);
                    o_wr_data = mk_cell(r_mat);
                end
                if (r_dx == ir) begin
                    n_dx = -ir;
                    if (r_dy == ir) begin
                        n_state = ST_DONE;
                    end else begin
                        n_dy = r_dy + 7'sd1;
                    end
                end else begin
                    n_dx = r_dx + 7'sd1;
                end
            end
            ST_FS_RD: begin
                o_rd_addr = cell_addr(r_x, r_y);
                n_state   = ST_FS_CUR;
            end
            ST_FS_CUR: begin
                n_c = i_rd_data;
                if (i_rd_data[3:0] == MAT_EMPTY || i_rd_data[3:0] == MAT_WALL) begin
                    n_state = ST_FS_NEXT;
                end else begin
                    n_state   = ST_FS_BELOW;
                    o_rd_addr = cell_addr(r_x, r_y + 9'd1);
                    if (i_rd_data[3:0] == MAT_EMBER) begin
                        n_rng = xs32(r_rng);
                        if (n_rng[2:0] == 3'd0 && i_rd_data[7:4] != 4'd0) begin
                            if (i_rd_data[7:4] == 4'd1) begin
                                n_state = ST_FS_ASH;
                            end else begin
                                n_c       = {i_rd_data[7:4] - 4'd1, MAT_EMBER};
                                o_wr_en   = 1'b1;
                                o_wr_addr = cell_addr(r_x, r_y);
                                o_wr_data = n_c;
                            end
                        end
                    end
                end
            end
            ST_FS_ASH: begin
                n_rng     = rnd1;
                n_c       = (rnd1[1:0] == 2'd0) ? {4'd0, MAT_SAND} : 8'd0;
                o_wr_en   = 1'b1;
                o_wr_addr = cell_addr(r_x, r_y);
                o_wr_data = n_c;
                if (rnd1[1:0] == 2'd0) begin
                    o_rd_addr = cell_addr(r_x, r_y + 9'd1);
                    n_state   = ST_FS_BELOW;
                end else begin
                    n_state = ST_FS_NEXT;
                end
            end
            ST_FS_BELOW: begin
                if (i_rd_data[3:0] == MAT_EMPTY ||
                    (m == MAT_OIL && i_rd_data[3:0] == MAT_WATER)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cell_addr(r_x, r_y + 9'd1);
                    o_wr_data = r_c;
                    n_w2      = {4'd0, i_rd_data[3:0]};
                    n_state   = ST_FS_WR2;
                end else begin
                    n_t     = 1'b0;
                    n_state = ST_FS_DIAG_ISS;
                end
            end
            ST_FS_DIAG_ISS: begin
                if (nb_ok) begin
                    n_nx      = nb_x;
                    o_rd_addr = cell_addr(nb_x, r_y + 9'd1);
                    n_state   = ST_FS_DIAG;
                end else if (!r_t) begin
                    n_t = 1'b1;
                end else begin
                    n_t     = 1'b0;
                    n_state = liq ? ST_FS_SIDE_ISS : ST_FS_NEXT;
                end
            end
            ST_FS_DIAG: begin
                if (i_rd_data[3:0] == MAT_EMPTY ||
                    (m == MAT_OIL && i_rd_data[3:0] == MAT_WATER)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cell_addr(r_nx, r_y + 9'd1);
                    o_wr_data = r_c;
                    n_w2      = {4'd0, i_rd_data[3:0]};
                    n_state   = ST_FS_WR2;
                end else if (!r_t) begin
                    n_t     = 1'b1;
                    n_state = ST_FS_DIAG_ISS;
                end else begin
                    n_t     = 1'b0;
                    n_state = liq ? ST_FS_SIDE_ISS : ST_FS_NEXT;
                end
            end
            ST_FS_SIDE_ISS: begin
                if (nb_ok) begin
                    n_nx      = nb_x;
                    o_rd_addr = cell_addr(nb_x, r_y);
                    n_state   = ST_FS_SIDE;
                end else if (!r_t) begin
                    n_t = 1'b1;
                end else begin
                    n_state = ST_FS_NEXT;
                end
            end
            ST_FS_SIDE: begin
                if (i_rd_data[3:0] == MAT_EMPTY) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cell_addr(r_nx, r_y);
                    o_wr_data = r_c;
                    n_w2      = 8'd0;
                    n_state   = ST_FS_WR2;
                end else if (!r_t) begin
                    n_t     = 1'b1;
                    n_state = ST_FS_SIDE_ISS;
                end else begin
                    n_state = ST_FS_NEXT;
                end
            end
            ST_FS_WR2: begin
                o_wr_en   = 1'b1;
                o_wr_addr = cell_addr(r_x, r_y);
                o_wr_data = r_w2;
                n_state   = ST_FS_NEXT;
            end
            ST_FS_NEXT: begin
                if (r_lf ? ((r_x + 9'd1) == i_cfg.gw) : (r_x == 9'd0)) begin
                    if (r_y == 9'd0) begin
                        n_x     = amb_x0;
                        n_aend  = cx + span;
                        n_state = i_cfg.amb_en ? ST_AM_ISS : ST_DONE;
                    end else begin
                        n_y     = r_y - 9'd1;
                        n_x     = r_lf ? 9'd0 : (i_cfg.gw - 9'd1);
                        n_state = ST_FS_RD;
                    end
                end else begin
                    n_x     = r_lf ? (r_x + 9'd1) : (r_x - 9'd1);
                    n_state = ST_FS_RD;
                end
            end
            ST_AM_ISS: begin
                if (r_x < i_cfg.gw) begin
                    n_rng = rnd1;
                end
                if (r_x < i_cfg.gw && rnd1[1:0] == 2'd0) begin
                    o_rd_addr = cell_addr(r_x, 9'd0);
                    n_state   = ST_AM_CHK;
                end else if (r_x == r_aend) begin
                    n_state = ST_DONE;
                end else begin
                    n_x = r_x + 9'd1;
                end
            end
            ST_AM_CHK: begin
                if (i_rd_data[3:0] == MAT_EMPTY) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = cell_addr(r_x, 9'd0);
                    o_wr_data = mk_cell(amb_mat);
                end
                if (r_x == r_aend) begin
                    n_state = ST_DONE;
                end else begin
                    n_x     = r_x + 9'd1;
                    n_state = ST_AM_ISS;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_ocmd   = r_cmd;
                    n_oval   = r_dval;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // a size change wipes the grid; no result is reported for it
        if (i_cfg.resize) begin
            n_sweep   = '0;
            n_clr_rep = 1'b0;
            n_state   = ST_SWEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_sweep   <= '0;
            r_clr_rep <= 1'b0;
            r_rng     <= RNG_SEED;
            r_lf      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sweep   <= n_sweep;
            r_clr_rep <= n_clr_rep;
            r_rng     <= n_rng;
            r_lf      <= n_lf;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_nx <= n_nx; r_aend <= n_aend; r_t <= n_t;
        r_c <= n_c; r_w2 <= n_w2; r_cmd <= n_cmd; r_px <= n_px; r_py <= n_py;
        r_rad <= n_rad; r_mat <= n_mat; r_dx <= n_dx; r_dy <= n_dy;
        r_dval <= n_dval; r_ocmd <= n_ocmd; r_oval <= n_oval;
    end

    assign o_res.valid        = r_ovalid;
    assign o_res.command_done = r_ocmd;
    assign o_res.cell_value   = r_oval;
endmodule
`default_nettype wire

>>> hw/rtl/falling_sand_grid_step_top.sv
// Top level of the falling sand grid block: config, sequencer and cell RAM.
//
//  channel  | dir | fields                                        | transfer when
//  ---------+-----+-----------------------------------------------+-----------------
//  i_cmd    | in  | command, pos_x, pos_y, radius, material       | valid && ready
//  o_res    | out | command_done, cell_value                      | valid && ready
//  i_cfg    | in  | reg_index, wdata                              | valid (ready tied high)
//
//  One command at a time; the RAM has one read and one write port, read data registered.
//  Clear writes one RAM entry per cycle. Reset and any size change run a clearing pass
//  over all 2^(log2 W + log2 H) RAM entries (65536 by default), during which no command
//  is taken; config writes still land. A finished result sits in the output register while
//  the next command is taken.
`default_nettype none
module falling_sand_grid_step_top #(
    parameter int MAX_WIDTH  = fsg_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fsg_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fsg_cmd_if.sink   i_cmd,
    fsg_res_if.source o_res,
    fsg_cfg_if.sink   i_cfg
);
    import fsg_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
    localparam int DEPTH = 2 ** AW;

    t_cfg          cfg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [7:0]    rd_data, wr_data;
    logic          wr_en;

    // register file; flags a resize that must wipe the grid
    fsg_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // command sequencer: all read-modify-write traffic to the grid
    fsg_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .AW(AW)) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .i_cfg     (cfg),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // cell store, addressed {row, column}
    fsg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );
endmodule
`default_nettype wire

>>> hw/rtl/fsg_chk.sv
// Port-level checker for the falling sand grid block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module fsg_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] i_out_cmd,
    input wire logic [7:0] i_out_val
);
    import fsg_pkg::*;

    logic in_xfer, out_stall, out_not_read;

    assign in_xfer      = i_in_valid && i_in_ready;
    assign out_stall    = i_out_valid && !i_out_ready;
    assign out_not_read = i_out_valid && (i_out_cmd != CMD_READ);

    `FSG_ASSERT_NEXT_ALWAYS(a_out_idle_after_rst, i_clk, !i_rst_n, !i_out_valid)
    `FSG_ASSERT_NEXT(a_one_cmd_at_a_time, i_clk, i_rst_n, in_xfer, !i_in_ready)
    `FSG_ASSERT_NOW(a_value_only_on_read, i_clk, i_rst_n, out_not_read, i_out_val == 8'd0)
    `FSG_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, out_stall, i_out_valid)
endmodule

bind falling_sand_grid_step_top fsg_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_cmd   (o_res.command_done),
    .i_out_val   (o_res.cell_value)
);
`default_nettype wire
